// ===== rtl/rbct_pkg.sv =====
// Package for the red blob centroid tracker.
// Holds the field widths, the queue entry type, the back-end state type and the constants.
// Depends on nothing.
`timescale 1ns / 1ps

package rbct_pkg;

   localparam int PIX_W    = 8;
   localparam int COORD_W  = 11;
   localparam int CNT_W    = 23;
   localparam int SUM_W    = 34;
   localparam int RAD_W    = 11;
   localparam int LUMA_W   = 16;
   localparam int CHROMA_W = 10;
   localparam int STEP_W   = 6;
   localparam int LIM_W    = 30;
   localparam int SQ_W     = 22;
   localparam int AREA_W   = 31;
   localparam int Q_AW     = 2;
   localparam int Q_FILL_W = 3;

   localparam logic [Q_FILL_W-1:0] Q_DEPTH        = 3'd4;
   localparam logic [PIX_W-1:0]    MIN_LUMA_RESET = 8'd50;
   localparam logic [CNT_W-1:0]    CNT_MAX        = 23'h7F_FFFF;
   localparam logic [COORD_W-1:0]  COORD_MAX      = 11'd2047;
   localparam logic [STEP_W-1:0]   DIV_STEPS      = 6'd34;
   localparam logic [RAD_W-1:0]    ROOT_TOP_BIT   = 11'h400;

   localparam logic [LUMA_W-1:0] LUMA_B_WEIGHT = 16'd11;
   localparam logic [LUMA_W-1:0] LUMA_G_WEIGHT = 16'd59;
   localparam logic [LUMA_W-1:0] LUMA_R_WEIGHT = 16'd30;
   localparam logic [LUMA_W-1:0] RED_WEIGHT    = 16'd200;
   localparam logic [LUMA_W-1:0] LUMA_SCALE    = 16'd100;
   localparam logic [LIM_W-1:0]  AREA_SCALE    = 30'd100;
   localparam logic [AREA_W-1:0] AREA_PI       = 31'd314;

   typedef struct packed {
      logic               mask;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               eof;
   } pixel_entry_type;

   typedef enum logic [1:0] {
      BK_PIXEL,
      BK_CALC,
      BK_SUMMARY
   } back_state_type;

endpackage

// ===== rtl/rbct_front.sv =====
// Front end of the red blob centroid tracker: holds min_luma and classifies each pixel.
// Depends on rbct_pkg.
`timescale 1ns / 1ps

module rbct_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [rbct_pkg::PIX_W-1:0]   req_blue,
   input  logic [rbct_pkg::PIX_W-1:0]   req_green,
   input  logic [rbct_pkg::PIX_W-1:0]   req_red,
   input  logic [rbct_pkg::COORD_W-1:0] req_col,
   input  logic [rbct_pkg::COORD_W-1:0] req_row,
   input  logic                        req_end_of_frame,
   input  logic                        csr_write,
   input  logic [rbct_pkg::PIX_W-1:0]   csr_wdata,
   input  logic                        q_full,
   output logic                        q_push,
   output rbct_pkg::pixel_entry_type   q_entry
);
   import rbct_pkg::*;

   logic [PIX_W-1:0]    min_luma_ff;
   logic [PIX_W-1:0]    min_luma_in;
   logic [LUMA_W-1:0]   luma100;
   logic [LUMA_W-1:0]   red200;
   logic [LUMA_W-1:0]   luma_floor;
   logic [CHROMA_W-1:0] red2;
   logic [CHROMA_W-1:0] blue3;
   logic [CHROMA_W-1:0] green3;
   logic                is_red;

   always_comb begin
      min_luma_in = csr_write ? csr_wdata : min_luma_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_luma_ff <= MIN_LUMA_RESET;
      end else begin
         min_luma_ff <= min_luma_in;
      end
   end

   always_comb begin
      luma100    = LUMA_B_WEIGHT * LUMA_W'(req_blue) + LUMA_G_WEIGHT * LUMA_W'(req_green)
                 + LUMA_R_WEIGHT * LUMA_W'(req_red);
      red200     = RED_WEIGHT * LUMA_W'(req_red);
      luma_floor = LUMA_SCALE * LUMA_W'(min_luma_ff);
      red2       = CHROMA_W'(req_red) << 1;
      blue3      = CHROMA_W'(req_blue) + (CHROMA_W'(req_blue) << 1);
      green3     = CHROMA_W'(req_green) + (CHROMA_W'(req_green) << 1);
      is_red     = (red200 > luma100) && (red2 > blue3) && (red2 > green3)
                 && (luma100 > luma_floor);
   end

   assign full          = q_full;
   assign q_push        = push && !q_full;
   assign q_entry.mask  = is_red;
   assign q_entry.col   = req_col;
   assign q_entry.row   = req_row;
   assign q_entry.eof   = req_end_of_frame;

endmodule

// ===== rtl/rbct_queue.sv =====
// Short queue of classified pixel items between the front and the back end.
// Depends on rbct_pkg.
`timescale 1ns / 1ps

module rbct_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  rbct_pkg::pixel_entry_type wr_entry,
   output logic                      q_full,
   input  logic                      rd_en,
   output rbct_pkg::pixel_entry_type rd_entry,
   output logic                      q_empty
);
   import rbct_pkg::*;

   pixel_entry_type       slot_ff [2**Q_AW];
   logic [Q_AW-1:0]       wr_ptr_ff;
   logic [Q_AW-1:0]       wr_ptr_in;
   logic [Q_AW-1:0]       rd_ptr_ff;
   logic [Q_AW-1:0]       rd_ptr_in;
   logic [Q_FILL_W-1:0]   fill_ff;
   logic [Q_FILL_W-1:0]   fill_in;

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (wr_en && !rd_en) begin
         fill_in = fill_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   assign rd_entry = slot_ff[rd_ptr_ff];
   assign q_full   = (fill_ff == Q_DEPTH);
   assign q_empty  = (fill_ff == '0);

endmodule

// ===== rtl/rbct_back.sv =====
// Back end of the red blob centroid tracker: accumulates red pixels, runs the centroid
// division and the radius search, and holds the result register. Depends on rbct_pkg.
`timescale 1ns / 1ps

module rbct_back (
   input  logic                        clock,
   input  logic                        reset,
   input  rbct_pkg::pixel_entry_type   q_head,
   input  logic                        q_empty,
   output logic                        q_pop,
   output logic                        empty,
   input  logic                        pop,
   output logic                        rsp_is_summary,
   output logic                        rsp_mask,
   output logic [rbct_pkg::COORD_W-1:0] rsp_center_x,
   output logic [rbct_pkg::COORD_W-1:0] rsp_center_y,
   output logic [rbct_pkg::RAD_W-1:0]   rsp_radius,
   output logic [rbct_pkg::CNT_W-1:0]   rsp_pixel_count,
   output logic                        rsp_last
);
   import rbct_pkg::*;

   back_state_type     state_ff;
   back_state_type     state_in;
   logic               out_free;
   logic               take_pixel;
   logic               load_summary;
   logic               calc_run;

   logic               out_valid_ff;
   logic               out_valid_in;
   logic               out_summary_ff;
   logic               out_mask_ff;
   logic [COORD_W-1:0] out_cx_ff;
   logic [COORD_W-1:0] out_cy_ff;
   logic [RAD_W-1:0]   out_rad_ff;
   logic [CNT_W-1:0]   out_cnt_ff;
   logic               out_last_ff;

   logic [CNT_W-1:0]   acc_cnt_ff;
   logic [SUM_W-1:0]   acc_col_ff;
   logic [SUM_W-1:0]   acc_row_ff;
   logic [CNT_W-1:0]   cnt_new;
   logic [SUM_W:0]     col_sum;
   logic [SUM_W:0]     row_sum;
   logic [SUM_W-1:0]   col_new;
   logic [SUM_W-1:0]   row_new;

   logic [CNT_W-1:0]   cnt_ff;
   logic [SUM_W-1:0]   qc_ff;
   logic [SUM_W-1:0]   qr_ff;
   logic [CNT_W-1:0]   remc_ff;
   logic [CNT_W-1:0]   remr_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [CNT_W:0]     trial_c;
   logic [CNT_W:0]     trial_r;
   logic [CNT_W:0]     divisor;
   logic               ge_c;
   logic               ge_r;
   logic [CNT_W:0]     diff_c;
   logic [CNT_W:0]     diff_r;

   logic [LIM_W-1:0]   lim_ff;
   logic [RAD_W-1:0]   root_ff;
   logic [RAD_W-1:0]   bit_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic               phase_ff;
   logic [RAD_W-1:0]   trial_root;
   logic [SQ_W-1:0]    sq_in;
   logic [AREA_W-1:0]  area;
   logic               root_fits;

   logic [COORD_W-1:0] mean_x;
   logic [COORD_W-1:0] mean_y;

   assign out_free = !out_valid_ff || pop;

   always_comb begin
      take_pixel   = 1'b0;
      load_summary = 1'b0;
      calc_run     = 1'b0;
      unique case (state_ff)
         BK_PIXEL: begin
            take_pixel = !q_empty && out_free;
         end
         BK_CALC: begin
            calc_run = 1'b1;
         end
         BK_SUMMARY: begin
            load_summary = out_free;
         end
         default: begin
            take_pixel = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_PIXEL: begin
            if (take_pixel && q_head.eof) begin
               state_in = BK_CALC;
            end
         end
         BK_CALC: begin
            if (step_ff == STEP_W'(1)) begin
               state_in = BK_SUMMARY;
            end
         end
         BK_SUMMARY: begin
            if (load_summary) begin
               state_in = BK_PIXEL;
            end
         end
         default: begin
            state_in = BK_PIXEL;
         end
      endcase
   end

   always_comb begin
      cnt_new = (acc_cnt_ff == CNT_MAX) ? CNT_MAX : acc_cnt_ff + 1'b1;
      col_sum = {1'b0, acc_col_ff} + (SUM_W + 1)'(q_head.col);
      row_sum = {1'b0, acc_row_ff} + (SUM_W + 1)'(q_head.row);
      col_new = col_sum[SUM_W] ? '1 : col_sum[SUM_W-1:0];
      row_new = row_sum[SUM_W] ? '1 : row_sum[SUM_W-1:0];
   end

   always_comb begin
      divisor = {1'b0, cnt_ff};
      trial_c = {remc_ff, qc_ff[SUM_W-1]};
      trial_r = {remr_ff, qr_ff[SUM_W-1]};
      ge_c    = trial_c >= divisor;
      ge_r    = trial_r >= divisor;
      diff_c  = ge_c ? trial_c - divisor : trial_c;
      diff_r  = ge_r ? trial_r - divisor : trial_r;
   end

   always_comb begin
      trial_root = root_ff | bit_ff;
      sq_in      = SQ_W'({11'd0, trial_root} * {11'd0, trial_root});
      area       = AREA_W'(sq_ff) * AREA_PI;
      root_fits  = area <= {1'b0, lim_ff};
   end

   always_comb begin
      mean_x = '0;
      mean_y = '0;
      if (cnt_ff != '0) begin
         mean_x = (|qc_ff[SUM_W-1:COORD_W]) ? COORD_MAX : qc_ff[COORD_W-1:0];
         mean_y = (|qr_ff[SUM_W-1:COORD_W]) ? COORD_MAX : qr_ff[COORD_W-1:0];
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !pop;
      if (take_pixel || load_summary) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_PIXEL;
         out_valid_ff <= 1'b0;
         acc_cnt_ff   <= '0;
         acc_col_ff   <= '0;
         acc_row_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         if (take_pixel && q_head.mask && !q_head.eof) begin
            acc_cnt_ff <= cnt_new;
            acc_col_ff <= col_new;
            acc_row_ff <= row_new;
         end else if (take_pixel && q_head.eof) begin
            acc_cnt_ff <= '0;
            acc_col_ff <= '0;
            acc_row_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_pixel) begin
         out_summary_ff <= 1'b0;
         out_mask_ff    <= q_head.mask;
         out_cx_ff      <= '0;
         out_cy_ff      <= '0;
         out_rad_ff     <= '0;
         out_cnt_ff     <= '0;
         out_last_ff    <= !q_head.eof;
      end else if (load_summary) begin
         out_summary_ff <= 1'b1;
         out_mask_ff    <= 1'b0;
         out_cx_ff      <= mean_x;
         out_cy_ff      <= mean_y;
         out_rad_ff     <= root_ff;
         out_cnt_ff     <= cnt_ff;
         out_last_ff    <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take_pixel && q_head.eof) begin
         cnt_ff   <= q_head.mask ? cnt_new : acc_cnt_ff;
         qc_ff    <= q_head.mask ? col_new : acc_col_ff;
         qr_ff    <= q_head.mask ? row_new : acc_row_ff;
         remc_ff  <= '0;
         remr_ff  <= '0;
         step_ff  <= DIV_STEPS;
         root_ff  <= '0;
         bit_ff   <= ROOT_TOP_BIT;
         phase_ff <= 1'b0;
      end else if (calc_run) begin
         lim_ff <= LIM_W'(cnt_ff) * AREA_SCALE;
         if (step_ff != '0) begin
            remc_ff <= diff_c[CNT_W-1:0];
            remr_ff <= diff_r[CNT_W-1:0];
            qc_ff   <= {qc_ff[SUM_W-2:0], ge_c};
            qr_ff   <= {qr_ff[SUM_W-2:0], ge_r};
            step_ff <= step_ff - 1'b1;
         end
         if (bit_ff != '0) begin
            if (!phase_ff) begin
               sq_ff <= sq_in;
            end else begin
               if (root_fits) begin
                  root_ff <= trial_root;
               end
               bit_ff <= bit_ff >> 1;
            end
            phase_ff <= !phase_ff;
         end
      end
   end

   assign q_pop           = take_pixel;
   assign empty           = !out_valid_ff;
   assign rsp_is_summary  = out_summary_ff;
   assign rsp_mask        = out_mask_ff;
   assign rsp_center_x    = out_cx_ff;
   assign rsp_center_y    = out_cy_ff;
   assign rsp_radius      = out_rad_ff;
   assign rsp_pixel_count = out_cnt_ff;
   assign rsp_last        = out_last_ff;

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("Queue popped while empty.");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !pop) |=> (out_valid_ff && $stable(out_summary_ff)
                                  && $stable(out_mask_ff) && $stable(out_cnt_ff)))
      else $error("Waiting result item was overwritten.");

   a_remainder_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CALC && cnt_ff != '0) |-> (remc_ff < cnt_ff && remr_ff < cnt_ff))
      else $error("Divider remainder not below the divisor.");

   a_root_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SUMMARY) |-> (bit_ff == '0))
      else $error("Radius search unfinished at summary time.");

endmodule

// ===== rtl/red_blob_centroid_tracker.sv =====
// Top level of the red blob centroid tracker.
// Instantiates rbct_front, rbct_queue and rbct_back; depends on rbct_pkg.
`timescale 1ns / 1ps
//
//  Channel   Ports                                    Accepted when
//  input     push, full, req_*                        push && !full
//  result    empty, pop, rsp_*                        pop && !empty
//  config    csr_write, csr_wdata (min_luma)          csr_write
//
//  Each pixel item goes through a queue slot to the result register, one item a cycle while
//  results are popped and the back end is in its pixel state. The last pixel of a frame starts
//  a shift-subtract division, with the radius search run alongside, and then loads the summary item.
//  A four-item queue takes pixels meanwhile; full rises once it is filled.
//  Synchronous reset empties the queue and the result register, clears the sums and
//  sets min_luma to 50. A result item waiting for pop holds the back end only.

module red_blob_centroid_tracker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [rbct_pkg::PIX_W-1:0]   req_blue,
   input  logic [rbct_pkg::PIX_W-1:0]   req_green,
   input  logic [rbct_pkg::PIX_W-1:0]   req_red,
   input  logic [rbct_pkg::COORD_W-1:0] req_col,
   input  logic [rbct_pkg::COORD_W-1:0] req_row,
   input  logic                        req_end_of_frame,
   input  logic                        csr_write,
   input  logic [rbct_pkg::PIX_W-1:0]   csr_wdata,
   output logic                        empty,
   input  logic                        pop,
   output logic                        rsp_is_summary,
   output logic                        rsp_mask,
   output logic [rbct_pkg::COORD_W-1:0] rsp_center_x,
   output logic [rbct_pkg::COORD_W-1:0] rsp_center_y,
   output logic [rbct_pkg::RAD_W-1:0]   rsp_radius,
   output logic [rbct_pkg::CNT_W-1:0]   rsp_pixel_count,
   output logic                        rsp_last
);
   import rbct_pkg::*;

   logic            q_full;
   logic            q_empty;
   logic            q_push;
   logic            q_pop;
   pixel_entry_type q_entry;
   pixel_entry_type q_head;

   rbct_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_blue         (req_blue),
      .req_green        (req_green),
      .req_red          (req_red),
      .req_col          (req_col),
      .req_row          (req_row),
      .req_end_of_frame (req_end_of_frame),
      .csr_write        (csr_write),
      .csr_wdata        (csr_wdata),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (q_entry)
   );

   rbct_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (q_push),
      .wr_entry (q_entry),
      .q_full   (q_full),
      .rd_en    (q_pop),
      .rd_entry (q_head),
      .q_empty  (q_empty)
   );

   rbct_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (q_head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_is_summary  (rsp_is_summary),
      .rsp_mask        (rsp_mask),
      .rsp_center_x    (rsp_center_x),
      .rsp_center_y    (rsp_center_y),
      .rsp_radius      (rsp_radius),
      .rsp_pixel_count (rsp_pixel_count),
      .rsp_last        (rsp_last)
   );

endmodule
